// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication property on the rising clock edge, off while in reset.
`define SGRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge, off while in reset.
`define SGRT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/sgrt_pkg.sv =====
// Shared types and constants of the scatter/gather residual tracker.
package sgrt_pkg;

    localparam int SGRT_MAX_SEGS_DEFAULT = 16;

    localparam int CMD_W    = 2;
    localparam int TOTAL_W  = 5;
    localparam int POS_W    = 4;
    localparam int INDEX_W  = 5;
    localparam int WORD_W   = 32;
    localparam int RESID_W  = 36;
    localparam int LEFT_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic set_counts;
        logic load_write;
        logic upd_apply;
        logic upd_read;
        logic upd_write;
        logic walk_start;
        logic walk_step;
        logic walk_acc;
        logic result_sum;
        logic finish;
    } sgrt_ctrl_t;

    // Datapath to controller status.
    typedef struct packed {
        cmd_t cmd;
        logic load_ok;
        logic load_write;
        logic upd_adjust;
        logic walk_empty;
        logic walk_last;
    } sgrt_stat_t;

endpackage

// ===== rtl/core/sgrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sgrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/sgrt_ctrl.sv =====
// Sequencing state machine of the scatter/gather residual tracker.
module sgrt_ctrl import sgrt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  sgrt_stat_t stat,
    output sgrt_ctrl_t ctrl
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_UPD_WR = 4'b0100,
        S_WALK   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.cmd)
                    CMD_LOAD:
                    begin
                        ctrl.set_counts = stat.load_ok;
                        ctrl.load_write = stat.load_ok & stat.load_write;
                        ctrl.finish     = 1'b1;
                        state_next      = S_IDLE;
                    end
                    CMD_UPDATE:
                    begin
                        ctrl.upd_apply = 1'b1;
                        if (stat.upd_adjust)
                        begin
                            ctrl.upd_read = 1'b1;
                            state_next    = S_UPD_WR;
                        end
                        else
                        begin
                            ctrl.finish = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (stat.walk_empty)
                        begin
                            ctrl.finish = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            ctrl.walk_start = 1'b1;
                            state_next      = S_WALK;
                        end
                    end
                    CMD_NOP:
                    begin
                        ctrl.finish = 1'b1;
                        state_next  = S_IDLE;
                    end
                endcase
            end
            S_UPD_WR:
            begin
                ctrl.upd_write = 1'b1;
                ctrl.finish    = 1'b1;
                state_next     = S_IDLE;
            end
            S_WALK:
            begin
                ctrl.walk_acc = 1'b1;
                if (stat.walk_last)
                begin
                    ctrl.result_sum = 1'b1;
                    ctrl.finish     = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    ctrl.walk_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/core/sgrt_datapath.sv =====
// Datapath: captured beat, segment table, counts and residual accumulator.
module sgrt_datapath import sgrt_pkg::*; #(
    parameter int MAX_SEGS = SGRT_MAX_SEGS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CMD_W-1:0]   command,
    input  logic [TOTAL_W-1:0] seg_total,
    input  logic [POS_W-1:0]   seg_position,
    input  logic [INDEX_W-1:0] seg_index,
    input  logic [WORD_W-1:0]  seg_address,
    input  logic [WORD_W-1:0]  seg_count,
    input  logic [WORD_W-1:0]  remain,
    input  sgrt_ctrl_t         ctrl,
    output sgrt_stat_t         stat,
    output logic               done,
    output logic [RESID_W-1:0] residual_bytes,
    output logic [LEFT_W-1:0]  segments_left
);

    localparam int IDX_W = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGS + 1);
    localparam int CMP_W = CNT_W + 6;

    cmd_t               cmd_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [WORD_W-1:0]  addr_reg;
    logic [WORD_W-1:0]  count_reg;
    logic [WORD_W-1:0]  remain_reg;

    logic [CNT_W-1:0]   saved_left_reg;
    logic [CNT_W-1:0]   current_left_reg;
    logic [IDX_W-1:0]   ptr_reg;
    logic [RESID_W-1:0] acc_reg;
    logic [RESID_W-1:0] residual_reg;
    logic               done_reg;

    logic               idx_in_range;
    logic [CNT_W-1:0]   upd_left;
    logic [IDX_W-1:0]   load_slot;
    logic [IDX_W-1:0]   walk_first;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               wr_en;
    logic [WORD_W-1:0]  wr_addr_data;
    logic [WORD_W-1:0]  wr_count_data;
    logic [WORD_W-1:0]  rd_addr_data;
    logic [WORD_W-1:0]  rd_count_data;
    logic [RESID_W-1:0] acc_sum;

    // Hold the accepted beat for the whole command.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg    <= cmd_t'(command);
            total_reg  <= seg_total;
            pos_reg    <= seg_position;
            index_reg  <= seg_index;
            addr_reg   <= seg_address;
            count_reg  <= seg_count;
            remain_reg <= remain;
        end
    end

    assign idx_in_range = CMP_W'(index_reg) < CMP_W'(MAX_SEGS);
    assign upd_left     = idx_in_range
                        ? CNT_W'(CMP_W'(MAX_SEGS) - CMP_W'(index_reg)
                                 - CMP_W'(remain_reg == '0))
                        : '0;
    assign load_slot    = IDX_W'(CMP_W'(MAX_SEGS) - CMP_W'(total_reg) + CMP_W'(pos_reg));
    assign walk_first   = IDX_W'(CMP_W'(MAX_SEGS) - CMP_W'(saved_left_reg));

    assign stat.cmd        = cmd_reg;
    assign stat.load_ok    = CMP_W'(total_reg) <= CMP_W'(MAX_SEGS);
    assign stat.load_write = {1'b0, pos_reg} < total_reg;
    assign stat.upd_adjust = idx_in_range && (remain_reg != '0);
    assign stat.walk_empty = (saved_left_reg == '0);
    assign stat.walk_last  = (ptr_reg == IDX_W'(MAX_SEGS - 1));

    // Table port muxing.
    always_comb
    begin
        rd_en   = ctrl.upd_read | ctrl.walk_start | ctrl.walk_step;
        rd_addr = IDX_W'(index_reg);
        if (ctrl.walk_start)
        begin
            rd_addr = walk_first;
        end
        else if (ctrl.walk_step)
        begin
            rd_addr = ptr_reg + IDX_W'(1);
        end

        wr_en         = ctrl.load_write | ctrl.upd_write;
        wr_addr       = load_slot;
        wr_addr_data  = addr_reg;
        wr_count_data = count_reg;
        if (ctrl.upd_write)
        begin
            wr_addr       = IDX_W'(index_reg);
            wr_addr_data  = rd_addr_data + (rd_count_data - remain_reg);
            wr_count_data = remain_reg;
        end
    end

    sgrt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_SEGS)
    ) u_addr_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_addr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_addr_data)
    );

    sgrt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_SEGS)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_count_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_count_data)
    );

    assign acc_sum = acc_reg + RESID_W'(rd_count_data);

    always_ff @(posedge clk)
    begin
        if (ctrl.walk_start)
        begin
            ptr_reg <= walk_first;
            acc_reg <= '0;
        end
        else if (ctrl.walk_acc)
        begin
            acc_reg <= acc_sum;
            if (ctrl.walk_step)
            begin
                ptr_reg <= ptr_reg + IDX_W'(1);
            end
        end
        if (ctrl.finish)
        begin
            residual_reg <= ctrl.result_sum ? acc_sum : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saved_left_reg   <= '0;
            current_left_reg <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.finish;
            if (ctrl.set_counts)
            begin
                saved_left_reg   <= CNT_W'(total_reg);
                current_left_reg <= CNT_W'(total_reg);
            end
            else if (ctrl.upd_apply)
            begin
                current_left_reg <= upd_left;
            end
        end
    end

    assign done           = done_reg;
    assign residual_bytes = residual_reg;
    assign segments_left  = LEFT_W'(current_left_reg);

endmodule

// ===== rtl/core/scatter_gather_residual_tracker_core.sv =====
// Sequence: a beat accepted while idle is decoded in the execute state; loads, simple updates,
//   no-ops and empty queries finish there, a partial-segment update adds a table write state,
//   and a residual query walks the saved slots; done is registered from the finishing state.
// Flow: one beat in flight; a new beat is taken while done shows; the walk reads one slot per cycle.
// Reset: rst_n clears the counts and control state; table entries stay unknown until loaded.
// Results are strobed for one cycle by done; the receiver cannot stall.
module scatter_gather_residual_tracker_core import sgrt_pkg::*; #(
    parameter int MAX_SEGS = SGRT_MAX_SEGS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   command,
    input  logic [TOTAL_W-1:0] seg_total,
    input  logic [POS_W-1:0]   seg_position,
    input  logic [INDEX_W-1:0] seg_index,
    input  logic [WORD_W-1:0]  seg_address,
    input  logic [WORD_W-1:0]  seg_count,
    input  logic [WORD_W-1:0]  remain,
    output logic               done,
    output logic [RESID_W-1:0] residual_bytes,
    output logic [LEFT_W-1:0]  segments_left
);

    // Command and status between the sequencer and the datapath.
    sgrt_ctrl_t ctrl;
    sgrt_stat_t stat;

    // The sequencer takes a beat whenever it sits idle and start is high. It then
    // decodes the captured command in an execute state: loads and simple updates
    // finish there, a partial-segment update adds a read-modify-write of the
    // table, and a residual query walks the table one slot per cycle from the
    // first occupied slot up to the last.
    sgrt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // The datapath holds the captured beat, the right-justified segment table
    // (address and count memories with registered reads), the saved and current
    // segments-left counts, the walk pointer and the 36-bit accumulator. The
    // result registers and the done strobe are loaded on the finishing cycle.
    sgrt_datapath #(
        .MAX_SEGS (MAX_SEGS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .command        (command),
        .seg_total      (seg_total),
        .seg_position   (seg_position),
        .seg_index      (seg_index),
        .seg_address    (seg_address),
        .seg_count      (seg_count),
        .remain         (remain),
        .ctrl           (ctrl),
        .stat           (stat),
        .done           (done),
        .residual_bytes (residual_bytes),
        .segments_left  (segments_left)
    );

endmodule

// ===== rtl/core/sgrt_checker.sv =====
// Port-level assertions for the tracker core, with the bind that attaches them.
`include "assert_macros.svh"

module sgrt_checker import sgrt_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [CMD_W-1:0]   command,
    input  logic [TOTAL_W-1:0] seg_total,
    input  logic [POS_W-1:0]   seg_position,
    input  logic [INDEX_W-1:0] seg_index,
    input  logic [WORD_W-1:0]  seg_address,
    input  logic [WORD_W-1:0]  seg_count,
    input  logic [WORD_W-1:0]  remain,
    input  logic               done,
    input  logic [RESID_W-1:0] residual_bytes,
    input  logic [LEFT_W-1:0]  segments_left
);

    `SGRT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
    `SGRT_ASSERT(a_busy_needs_start, $rose(busy) |-> $past(start), "busy rose without a beat")
    `SGRT_ASSERT(a_done_after_busy, done |-> $past(busy), "done without work in progress")
    `SGRT_NEVER(a_done_twice, done && $past(done), "done strobed on back-to-back cycles")

endmodule

bind scatter_gather_residual_tracker_core sgrt_checker u_sgrt_checker (.*);

// ===== verif/tb_scatter_gather_residual_tracker_core.sv =====
// Self-checking testbench for the scatter/gather residual tracker core.
`timescale 1ns / 1ps

module tb_scatter_gather_residual_tracker_core;
    import sgrt_pkg::*;

    localparam int MAX_SEGS       = SGRT_MAX_SEGS_DEFAULT;
    localparam int ITEM_TARGET    = 1850;
    localparam int WATCHDOG_LIMIT = 2000;

    // One result beat: residual sum and segments-left count.
    typedef struct packed {
        logic [RESID_W-1:0] resid;
        logic [LEFT_W-1:0]  left;
    } tally_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic [CMD_W-1:0]   command      = '0;
    logic [TOTAL_W-1:0] seg_total    = '0;
    logic [POS_W-1:0]   seg_position = '0;
    logic [INDEX_W-1:0] seg_index    = '0;
    logic [WORD_W-1:0]  seg_address  = '0;
    logic [WORD_W-1:0]  seg_count    = '0;
    logic [WORD_W-1:0]  remain       = '0;
    logic               done;
    logic [RESID_W-1:0] residual_bytes;
    logic [LEFT_W-1:0]  segments_left;

    // Shadow of the segment table and the two counts.
    logic [WORD_W-1:0] seg_addr_tab [MAX_SEGS];
    logic [WORD_W-1:0] seg_cnt_tab  [MAX_SEGS];
    int unsigned       saved_left;
    int unsigned       current_left;

    tally_t expected_tally [$];
    tally_t got_tally;
    tally_t want_tally;

    int fail_count      = 0;
    int results_checked = 0;
    int useful_beats    = 0;
    int ignored_beats   = 0;
    int load_beats      = 0;
    int update_beats    = 0;
    int query_beats     = 0;
    int burst_left      = 0;
    int idle_cycles     = 0;

    scatter_gather_residual_tracker_core #(
        .MAX_SEGS(MAX_SEGS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .seg_total     (seg_total),
        .seg_position  (seg_position),
        .seg_index     (seg_index),
        .seg_address   (seg_address),
        .seg_count     (seg_count),
        .remain        (remain),
        .done          (done),
        .residual_bytes(residual_bytes),
        .segments_left (segments_left)
    );

    always #6 clk = ~clk;

    // Apply one accepted beat to the shadow state and return the result it causes.
    function automatic tally_t apply_beat(cmd_t cmd, logic [TOTAL_W-1:0] n,
                                          logic [POS_W-1:0] p, logic [INDEX_W-1:0] idx,
                                          logic [WORD_W-1:0] addr, logic [WORD_W-1:0] cnt,
                                          logic [WORD_W-1:0] rem);
        tally_t t;
        int     slot;
        t.resid = '0;
        case (cmd)
            CMD_LOAD:
            begin
                // A list longer than the table is dropped without touching state.
                if (int'(n) <= MAX_SEGS)
                begin
                    saved_left   = 32'(n);
                    current_left = 32'(n);
                    if (p < n)
                    begin
                        slot               = MAX_SEGS - int'(n) + int'(p);
                        seg_addr_tab[slot] = addr;
                        seg_cnt_tab[slot]  = cnt;
                    end
                end
            end
            CMD_UPDATE:
            begin
                if (int'(idx) >= MAX_SEGS)
                    current_left = 0;
                else
                begin
                    current_left = MAX_SEGS - int'(idx);
                    if (rem == '0)
                    begin
                        if (current_left != 0)
                            current_left = current_left - 1;
                    end
                    else
                    begin
                        // Advance past the bytes already moved, keep the rest.
                        slot               = int'(idx);
                        seg_addr_tab[slot] = seg_addr_tab[slot] + (seg_cnt_tab[slot] - rem);
                        seg_cnt_tab[slot]  = rem;
                    end
                end
            end
            CMD_QUERY:
            begin
                for (slot = MAX_SEGS - int'(saved_left); slot < MAX_SEGS; slot++)
                    t.resid = t.resid + RESID_W'(seg_cnt_tab[slot]);
            end
            default:
            begin
            end
        endcase
        t.left = current_left[LEFT_W-1:0];
        return t;
    endfunction

    // Favor the corners of a 32-bit word.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1, 255);
            3:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Drive one beat, hold it until taken, then record its expected result.
    task automatic send_beat(cmd_t cmd, logic [TOTAL_W-1:0] n, logic [POS_W-1:0] p,
                             logic [INDEX_W-1:0] idx, logic [WORD_W-1:0] addr,
                             logic [WORD_W-1:0] cnt, logic [WORD_W-1:0] rem);
        int gap;
        start        <= 1'b1;
        command      <= cmd;
        seg_total    <= n;
        seg_position <= p;
        seg_index    <= idx;
        seg_address  <= addr;
        seg_count    <= cnt;
        remain       <= rem;
        do
            @(posedge clk);
        while (busy);
        expected_tally.push_back(apply_beat(cmd, n, p, idx, addr, cnt, rem));
        case (cmd)
            CMD_LOAD:   load_beats++;
            CMD_UPDATE: update_beats++;
            CMD_QUERY:  query_beats++;
            default:    ;
        endcase
        if (cmd == CMD_NOP || (cmd == CMD_LOAD && int'(n) > MAX_SEGS))
            ignored_beats++;
        else
            useful_beats++;
        // Sender runs in bursts; drop start for a random gap between them.
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic load_seg(int n, int p, logic [WORD_W-1:0] addr, logic [WORD_W-1:0] cnt);
        send_beat(CMD_LOAD, TOTAL_W'(n), POS_W'(p), INDEX_W'($urandom), addr, cnt, $urandom);
    endtask

    task automatic update_seg(int idx, logic [WORD_W-1:0] rem);
        send_beat(CMD_UPDATE, TOTAL_W'($urandom), POS_W'($urandom), INDEX_W'(idx),
                  $urandom, $urandom, rem);
    endtask

    task automatic query_resid();
        send_beat(CMD_QUERY, TOTAL_W'($urandom), POS_W'($urandom), INDEX_W'($urandom),
                  $urandom, $urandom, $urandom);
    endtask

    // Straight out of reset: no entry is written yet, so touch no table slot.
    task automatic test_reset_state();
        query_resid();
        send_beat(CMD_NOP, '1, '1, '1, '1, '1, '1);
    endtask

    // Fill the whole table with all-ones counts and read back the largest sum.
    task automatic test_full_table();
        int p;
        for (p = 0; p < MAX_SEGS; p++)
            load_seg(MAX_SEGS, p, (p % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF, '1);
        query_resid();
    endtask

    task automatic test_special_cases();
        load_seg(31, 3, 32'h1234_5678, 32'h55);       // list too long
        load_seg(4, 15, 32'hDEAD_BEEF, 32'h77);       // position beyond list
        update_seg(MAX_SEGS - 4, 32'd1);              // partial segment fix-up
        query_resid();
        update_seg(MAX_SEGS - 1, 32'd0);              // last segment complete
        update_seg(31, '1);                           // index beyond table
        load_seg(0, 0, '1, '1);                       // empty list
    endtask

    // Mostly whole lists walked by disconnects, the rest noise and broken lists.
    task automatic test_random_traffic();
        int               kind;
        int               n;
        int               p;
        int               slot;
        logic [WORD_W-1:0] rem;
        while (useful_beats < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: n = $urandom_range(1, 4);
                    6, 7, 8:          n = $urandom_range(5, MAX_SEGS - 1);
                    default:          n = MAX_SEGS;
                endcase
                for (p = 0; p < n; p++)
                    load_seg(n, p, pick_word(), pick_word());
                slot = MAX_SEGS - n;
                while (slot < MAX_SEGS && $urandom_range(0, 5) != 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                        query_resid();
                    case ($urandom_range(0, 3))
                        0:       rem = '0;
                        1:       rem = seg_cnt_tab[slot] >> $urandom_range(0, 31);
                        default: rem = pick_word();
                    endcase
                    update_seg(slot, rem);
                    if (rem == '0 || $urandom_range(0, 1) == 1)
                        slot++;
                end
                query_resid();
            end
            else if (kind < 8)
                send_beat(cmd_t'($urandom_range(0, 3)), TOTAL_W'($urandom_range(0, 31)),
                          POS_W'($urandom_range(0, 15)), INDEX_W'($urandom_range(0, 31)),
                          pick_word(), pick_word(), pick_word());
            else if (kind == 8)
            begin
                n = $urandom_range(0, 31);
                repeat ($urandom_range(1, 4))
                    load_seg(n, $urandom_range(0, 15), pick_word(), pick_word());
                query_resid();
            end
            else
            begin
                update_seg($urandom_range(0, 31), pick_word());
                query_resid();
            end
        end
    endtask

    // Each done cycle carries one result; compare it with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got_tally.resid = residual_bytes;
            got_tally.left  = segments_left;
            if (expected_tally.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual resid %h left %0d",
                         $time, got_tally.resid, got_tally.left);
                fail_count++;
            end
            else
            begin
                want_tally = expected_tally.pop_front();
                results_checked++;
                if (got_tally.resid !== want_tally.resid)
                begin
                    $display("%0t: residual_bytes mismatch: expected %h, actual %h",
                             $time, want_tally.resid, got_tally.resid);
                    fail_count++;
                end
                if (got_tally.left !== want_tally.left)
                begin
                    $display("%0t: segments_left mismatch: expected %0d, actual %0d",
                             $time, want_tally.left, got_tally.left);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run once nothing moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, expected_tally.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_full_table();
        test_special_cases();
        test_random_traffic();

        start <= 1'b0;
        while (expected_tally.size() != 0)
            @(posedge clk);
        // Hold a little longer so a stray extra result still gets caught.
        repeat (MAX_SEGS + 4) @(posedge clk);

        $display("Run covered %0d loads, %0d disconnect updates, %0d residual queries",
                 load_beats, update_beats, query_beats);
        $display("plus %0d ignored beats; %0d results compared", ignored_beats,
                 results_checked);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
